@@ rtl/oomr_pkg.sv @@
// Package with shared constants, types and helpers for the overwrite-oldest message ring.
`timescale 1ns / 1ps
package oomr_pkg;

  // Ring geometry.
  localparam int SLOTS      = 8;
  localparam int SLOT_BYTES = 256;
  localparam int SLOT_W     = $clog2(SLOTS);
  localparam int OFF_W      = $clog2(SLOT_BYTES);
  localparam int LEN_W      = OFF_W + 1;
  localparam int ADDR_W     = SLOT_W + OFF_W;

  // Fixed field widths of the interface.
  localparam int OP_W     = 2;
  localparam int DATA_W   = 8;
  localparam int STATUS_W = 3;
  localparam int CAP_W    = 9;
  localparam int IDX_W    = 3;
  localparam int ROFF_W   = 8;
  localparam int MLEN_W   = 9;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(256);
  localparam logic [LEN_W-1:0] SLOT_BYTES_LEN = LEN_W'(SLOT_BYTES);

  typedef enum logic [OP_W-1:0] {
    OP_STORE  = 2'd0,
    OP_GET    = 2'd1,
    OP_READ   = 2'd2,
    OP_UNUSED = 2'd3
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_TAKEN    = 3'd0,
    ST_STORED   = 3'd1,
    ST_TOO_LONG = 3'd2,
    ST_GOT      = 3'd3,
    ST_EMPTY    = 3'd4,
    ST_READ     = 3'd5
  } status_e;

  typedef enum logic {
    S_IDLE,
    S_RESP
  } state_e;

  // Controller to datapath.
  typedef struct packed {
    logic exec;
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic has_result;
  } stat_t;

  // Advance a slot pointer around the ring.
  function automatic logic [SLOT_W-1:0] slot_next(input logic [SLOT_W-1:0] s);
    logic [SLOT_W-1:0] r;
    if (s == SLOT_W'(SLOTS - 1)) begin
      r = '0;
    end else begin
      r = s + SLOT_W'(1);
    end
    return r;
  endfunction

endpackage

@@ rtl/oomr_ctrl.sv @@
// Controller state machine: input and result handshakes for the message ring.
`timescale 1ns / 1ps
module oomr_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output oomr_pkg::cmd_t cmd_o,
  input  oomr_pkg::stat_t stat_i
);
  import oomr_pkg::*;

  state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and handshake outputs.
  always_comb begin
    state_d     = state_q;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    cmd_o.exec  = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.exec = 1'b1;
          if (stat_i.has_result) begin
            state_d = S_RESP;
          end
        end
      end
      S_RESP: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // A result is never offered while a new item can be taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(in_ready_o && out_valid_o))
    else $error("input and result transfer enabled together");

  // An executed operation that yields a result shows it in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   cmd_o.exec && stat_i.has_result |=> out_valid_o)
    else $error("result missing after executed operation");

  // Execution only happens on an input transfer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   cmd_o.exec |-> (in_valid_i && in_ready_o))
    else $error("execute without input transfer");

endmodule

@@ rtl/oomr_dp.sv @@
// Datapath: message store, slot lengths, ring pointers and result registers.
`timescale 1ns / 1ps
module oomr_dp (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  oomr_pkg::cmd_t                  cmd_i,
  output oomr_pkg::stat_t                 stat_o,
  input  logic                            cfg_we_i,
  input  logic [oomr_pkg::CAP_W-1:0]      cfg_data_i,
  input  logic [oomr_pkg::OP_W-1:0]       op_i,
  input  logic [oomr_pkg::DATA_W-1:0]     data_byte_i,
  input  logic                            last_byte_i,
  input  logic [oomr_pkg::IDX_W-1:0]      read_slot_index_i,
  input  logic [oomr_pkg::ROFF_W-1:0]     read_offset_i,
  output logic [oomr_pkg::STATUS_W-1:0]   status_o,
  output logic [oomr_pkg::IDX_W-1:0]      slot_index_o,
  output logic [oomr_pkg::MLEN_W-1:0]     message_length_o,
  output logic [oomr_pkg::DATA_W-1:0]     read_data_o
);
  import oomr_pkg::*;

  // Message store and per-slot lengths, contents undefined until written.
  logic [DATA_W-1:0] mem [SLOTS*SLOT_BYTES];
  logic [LEN_W-1:0]  len_mem [SLOTS];
  logic [DATA_W-1:0] rd_q;

  // Ring control state.
  logic [SLOT_W-1:0] wp_q, wp_d;
  logic [SLOT_W-1:0] old_q, old_d;
  logic              any_q, any_d;
  logic [LEN_W-1:0]  bsf_q, bsf_d;
  logic              tls_q, tls_d;
  logic [CAP_W-1:0]  cap_q;

  // Result registers.
  status_e           status_q, status_d;
  logic [SLOT_W-1:0] slot_q, slot_d;
  logic [LEN_W-1:0]  len_q, len_d;
  logic              is_read_q;

  op_e               op;
  logic [LEN_W-1:0]  cap_eff;
  logic              take;
  logic              mem_we, mem_re, len_we;
  logic [ADDR_W-1:0] waddr, raddr;
  logic [SLOT_W-1:0] old_nx;
  logic [LEN_W-1:0]  commit_len;

  assign op = op_e'(op_i);
  assign stat_o.has_result = (op != OP_UNUSED);

  // Effective capacity is clipped to the slot size.
  assign cap_eff = (cap_q > CAP_W'(SLOT_BYTES)) ? SLOT_BYTES_LEN : LEN_W'(cap_q);
  assign take    = !tls_q && (bsf_q < cap_eff);
  assign waddr   = {wp_q, bsf_q[OFF_W-1:0]};
  assign raddr   = {read_slot_index_i[SLOT_W-1:0], read_offset_i[OFF_W-1:0]};
  assign old_nx  = slot_next(old_q);

  // Length at commit is the count including the final stored byte.
  assign commit_len = take ? (bsf_q + LEN_W'(1)) : bsf_q;

  // Operation decode and next-state logic.
  always_comb begin
    wp_d     = wp_q;
    old_d    = old_q;
    any_d    = any_q;
    bsf_d    = bsf_q;
    tls_d    = tls_q;
    status_d = status_q;
    slot_d   = slot_q;
    len_d    = len_q;
    mem_we   = 1'b0;
    mem_re   = 1'b0;
    len_we   = 1'b0;
    if (cmd_i.exec) begin
      slot_d = '0;
      len_d  = '0;
      unique case (op)
        OP_STORE: begin
          status_d = ST_TAKEN;
          if (take) begin
            mem_we = 1'b1;
            bsf_d  = bsf_q + LEN_W'(1);
          end else begin
            tls_d = 1'b1;
          end
          if (last_byte_i) begin
            if (tls_d) begin
              status_d = ST_TOO_LONG;
            end else begin
              // Commit; a full ring loses its oldest message.
              len_we = 1'b1;
              if (any_q && (wp_q == old_q)) begin
                old_d = old_nx;
              end
              if (!any_q) begin
                old_d = wp_q;
                any_d = 1'b1;
              end
              status_d = ST_STORED;
              slot_d   = wp_q;
              wp_d     = slot_next(wp_q);
            end
            bsf_d = '0;
            tls_d = 1'b0;
          end
        end
        OP_GET: begin
          if (any_q) begin
            status_d = ST_GOT;
            slot_d   = old_q;
            len_d    = len_mem[old_q];
            old_d    = old_nx;
            if (old_nx == wp_q) begin
              any_d = 1'b0;
            end
          end else begin
            status_d = ST_EMPTY;
          end
        end
        OP_READ: begin
          status_d = ST_READ;
          mem_re   = 1'b1;
        end
        default: ;
      endcase
    end
  end

  // Control and result registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q      <= '0;
      old_q     <= '0;
      any_q     <= 1'b0;
      bsf_q     <= '0;
      tls_q     <= 1'b0;
      cap_q     <= CAP_RESET;
      status_q  <= ST_TAKEN;
      slot_q    <= '0;
      len_q     <= '0;
      is_read_q <= 1'b0;
    end else begin
      wp_q     <= wp_d;
      old_q    <= old_d;
      any_q    <= any_d;
      bsf_q    <= bsf_d;
      tls_q    <= tls_d;
      status_q <= status_d;
      slot_q   <= slot_d;
      len_q    <= len_d;
      if (cmd_i.exec) begin
        is_read_q <= (op == OP_READ);
      end
      if (cfg_we_i) begin
        cap_q <= cfg_data_i;
      end
    end
  end

  // Message store: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[waddr] <= data_byte_i;
    end
    if (mem_re) begin
      rd_q <= mem[raddr];
    end
  end

  // Slot length table, written at commit.
  always_ff @(posedge clk_i) begin
    if (len_we) begin
      len_mem[wp_q] <= commit_len;
    end
  end

  assign status_o         = status_q;
  assign slot_index_o     = IDX_W'(slot_q);
  assign message_length_o = MLEN_W'(len_q);
  assign read_data_o      = is_read_q ? rd_q : '0;

  // An empty ring always has its oldest pointer on the write slot.
  assert property (@(posedge clk_i) disable iff (!rst_ni) !any_q |-> (old_q == wp_q))
    else $error("empty ring with oldest pointer off the write slot");

  // The byte count passes the clipped capacity only after a capacity write.
  assert property (@(posedge clk_i) disable iff (!rst_ni) bsf_q <= cap_eff || tls_q
                   || $past(cfg_we_i))
    else $error("byte count beyond capacity");

  // A commit always leaves the ring holding at least one message.
  assert property (@(posedge clk_i) disable iff (!rst_ni) len_we |=> any_q)
    else $error("commit left the ring empty");

endmodule

@@ rtl/overwrite_oldest_message_ring.sv @@
// Top level of the overwrite-oldest message ring: controller plus datapath.
// A result is offered in the cycle after its input transfer.
// A new item is not taken while a result waits; the single set of result registers holds
// the result until its transfer, and input is taken again only afterward.
// Unused operation code 3 gives no result and leaves input ready for the next item.
// Reset (asynchronous, active low) empties the ring and sets slot capacity to 256.
`timescale 1ns / 1ps
module overwrite_oldest_message_ring (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [oomr_pkg::CAP_W-1:0]      cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [oomr_pkg::OP_W-1:0]       op_i,
  input  logic [oomr_pkg::DATA_W-1:0]     data_byte_i,
  input  logic                            last_byte_i,
  input  logic [oomr_pkg::IDX_W-1:0]      read_slot_index_i,
  input  logic [oomr_pkg::ROFF_W-1:0]     read_offset_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [oomr_pkg::STATUS_W-1:0]   status_o,
  output logic [oomr_pkg::IDX_W-1:0]      slot_index_o,
  output logic [oomr_pkg::MLEN_W-1:0]     message_length_o,
  output logic [oomr_pkg::DATA_W-1:0]     read_data_o
);
  import oomr_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // The capacity register takes a write in any cycle.
  assign cfg_ready_o = 1'b1;

  oomr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd),
    .stat_i      (stat)
  );

  oomr_dp u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .stat_o            (stat),
    .cfg_we_i          (cfg_valid_i && cfg_ready_o),
    .cfg_data_i        (cfg_data_i),
    .op_i              (op_i),
    .data_byte_i       (data_byte_i),
    .last_byte_i       (last_byte_i),
    .read_slot_index_i (read_slot_index_i),
    .read_offset_i     (read_offset_i),
    .status_o          (status_o),
    .slot_index_o      (slot_index_o),
    .message_length_o  (message_length_o),
    .read_data_o       (read_data_o)
  );

endmodule
